// ===== design/msrd_pkg.sv =====
package msrd_pkg;

  // Phase of the deframer, one-hot.
  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_HEAD = 4'b0010,
    PH_PATH = 4'b0100,
    PH_BODY = 4'b1000
  } phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;
  localparam logic [1:0] KIND_ABORT   = 2'd3;

  // Request classes.
  localparam logic [1:0] REQ_POST    = 2'd0;
  localparam logic [1:0] REQ_GET     = 2'd1;
  localparam logic [1:0] REQ_STATUS  = 2'd2;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  // Method bytes.
  localparam logic [7:0] METHOD_POST   = 8'h50;
  localparam logic [7:0] METHOD_GET    = 8'h47;
  localparam logic [7:0] METHOD_STATUS = 8'h49;

  // Input operations.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAGIC    = 2'd0;
  localparam logic [1:0] REG_MAX_PATH = 2'd1;
  localparam logic [1:0] REG_MAX_BODY = 2'd2;
  localparam logic [1:0] REG_TIMEOUT  = 2'd3;

  // Register reset values.
  localparam logic [31:0] MAGIC_RESET    = 32'h4C52_5131;
  localparam logic [15:0] MAX_PATH_RESET = 16'd512;
  localparam logic [31:0] MAX_BODY_RESET = 32'd60000;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd3000;

  localparam int unsigned HDR_LAST = 6;
  localparam int unsigned OUT_DATA_W = 72;

  typedef struct packed {
    logic        path_empty;
    logic [31:0] body_length;
    logic [15:0] path_length;
    logic [7:0]  method_byte;
    logic [1:0]  request;
    logic        frame_end;
    logic [7:0]  payload;
    logic        in_body;
    logic [1:0]  kind;
  } result_t;

  function automatic logic [1:0] classify(input logic [7:0] m);
    logic [1:0] r;
    begin
      case (m)
        METHOD_POST:   r = REQ_POST;
        METHOD_GET:    r = REQ_GET;
        METHOD_STATUS: r = REQ_STATUS;
        default:       r = REQ_UNKNOWN;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== design/msrd_core.sv =====
module msrd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  logic                step_en,
  input  logic                op,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  output msrd_pkg::result_t   res
);
  import msrd_pkg::*;

  logic [31:0] magic_r, body_limit_r;
  logic [15:0] path_limit_r, timeout_r;

  phase_t      phase_r, phase_nxt;
  logic [31:0] window_r, window_nxt;
  logic [2:0]  hcount_r, hcount_nxt;
  logic [7:0]  method_r, method_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [31:0] blen_r, blen_nxt;
  logic [31:0] left_r, left_nxt;
  logic [15:0] time_r, time_nxt;
  logic [31:0] shifted;
  logic [31:0] left_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r      <= MAGIC_RESET;
      path_limit_r <= MAX_PATH_RESET;
      body_limit_r <= MAX_BODY_RESET;
      timeout_r    <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAGIC:    magic_r      <= cfg_wdata;
        REG_MAX_PATH: path_limit_r <= cfg_wdata[15:0];
        REG_MAX_BODY: body_limit_r <= cfg_wdata;
        REG_TIMEOUT:  timeout_r    <= cfg_wdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    window_nxt = window_r;
    hcount_nxt = hcount_r;
    method_nxt = method_r;
    plen_nxt   = plen_r;
    blen_nxt   = blen_r;
    left_nxt   = left_r;
    time_nxt   = time_r;
    res_valid  = 1'b0;
    res        = '0;
    shifted    = {window_r[23:0], rx_byte};
    left_dec   = (left_r != 32'd0) ? left_r - 32'd1 : left_r;

    if (op == OP_TICK) begin
      if (phase_r != PH_HUNT) begin
        if (time_r > 16'd1) begin
          time_nxt = time_r - 16'd1;
        end else begin
          time_nxt   = '0;
          phase_nxt  = PH_HUNT;
          window_nxt = '0;
          res_valid  = 1'b1;
          res.kind   = KIND_ABORT;
        end
      end
    end else begin
      unique case (phase_r)
        PH_HUNT: begin
          window_nxt = shifted;
          if (shifted == magic_r) begin
            window_nxt = '0;
            phase_nxt  = PH_HEAD;
            hcount_nxt = '0;
            method_nxt = '0;
            plen_nxt   = '0;
            blen_nxt   = '0;
            left_nxt   = '0;
            time_nxt   = timeout_r;
          end
        end
        PH_HEAD: begin
          if (hcount_r == 3'd0) begin
            method_nxt = rx_byte;
          end else if (hcount_r <= 3'd2) begin
            plen_nxt = {plen_r[7:0], rx_byte};
          end else begin
            blen_nxt = {blen_r[23:0], rx_byte};
          end
          hcount_nxt = hcount_r + 3'd1;
          if (hcount_r == 3'(HDR_LAST)) begin
            hcount_nxt      = '0;
            res.request     = classify(method_nxt);
            res.method_byte = method_nxt;
            res.path_length = plen_nxt;
            res.body_length = blen_nxt;
            res.path_empty  = (plen_nxt == 16'd0);
            if (plen_nxt > path_limit_r || blen_nxt > body_limit_r) begin
              phase_nxt = PH_HUNT;
              res_valid = 1'b1;
              res.kind  = KIND_REJECT;
            end else if (plen_nxt != 16'd0) begin
              phase_nxt = PH_PATH;
              left_nxt  = {16'd0, plen_nxt};
            end else if (blen_nxt != 32'd0) begin
              phase_nxt = PH_BODY;
              left_nxt  = blen_nxt;
            end else begin
              phase_nxt     = PH_HUNT;
              res_valid     = 1'b1;
              res.kind      = KIND_DONE;
              res.frame_end = 1'b1;
            end
          end
        end
        PH_PATH, PH_BODY: begin
          res_valid       = 1'b1;
          res.kind        = KIND_PAYLOAD;
          res.in_body     = (phase_r == PH_BODY);
          res.payload     = rx_byte;
          res.request     = classify(method_r);
          res.method_byte = method_r;
          res.path_length = plen_r;
          res.body_length = blen_r;
          res.path_empty  = (plen_r == 16'd0);
          left_nxt        = left_dec;
          if (left_dec == 32'd0) begin
            if (phase_r == PH_PATH && blen_r != 32'd0) begin
              phase_nxt = PH_BODY;
              left_nxt  = blen_r;
            end else begin
              phase_nxt     = PH_HUNT;
              res.frame_end = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end

    if (!step_en) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      window_r <= '0;
      hcount_r <= '0;
      method_r <= '0;
      plen_r   <= '0;
      blen_r   <= '0;
      left_r   <= '0;
      time_r   <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      window_r <= window_nxt;
      hcount_r <= hcount_nxt;
      method_r <= method_nxt;
      plen_r   <= plen_nxt;
      blen_r   <= blen_nxt;
      left_r   <= left_nxt;
      time_r   <= time_nxt;
    end
  end

`ifndef SYNTHESIS
  // An abort only ever comes from a tick.
  a_abort_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == KIND_ABORT) |-> (op == OP_TICK))
    else $error("abort result without a tick");

  // The header counter is clear whenever payload bytes are being forwarded.
  a_hcount_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (hcount_r != 3'd0) |-> (phase_r != PH_PATH && phase_r != PH_BODY))
    else $error("header count nonzero in a payload phase");

  // Leaving the payload phases always closes the frame.
  a_payload_end: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && op == OP_BYTE && (phase_r == PH_PATH || phase_r == PH_BODY)
     && phase_nxt == PH_HUNT) |-> (res_valid && res.frame_end))
    else $error("payload phase left without frame end");
`endif

endmodule

// ===== design/magic_sync_request_deframer.sv =====
// Magic-sync request deframer.
// The in_ channel carries one word per received serial byte or millisecond
// tick: in_tdata holds the byte, in_tuser is 1 for a tick. The block hunts for
// the configured magic word, collects a seven-byte header (method, 16-bit path
// length, 32-bit body length, big endian), then forwards path and body bytes.
// The out_ channel carries at most one result per input word: out_tuser is the
// result kind (payload, header-only done, reject, timeout abort), out_tlast
// marks the word that closes an accepted frame, and out_tdata carries the
// payload byte plus the decoded header fields.
// A result is registered at the edge that accepts its input word. The block
// accepts one word every cycle while in_tready is high; all work for a word is
// one pass of compare and count logic ahead of the result register.
// When the receiver stalls, one further result is held in a skid stage and
// in_tready drops only while that stage is full.
// Reset restores the default register values (sync word "LRQ1", path limit
// 512, body limit 60000, timeout 3000 ticks) and returns to hunting with an
// empty window. The cfg_ port writes one register per cycle at cfg_we.
module magic_sync_request_deframer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_index,
  input  logic [31:0]                           cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,   // rx_byte
  input  logic                                  in_tuser,   // operation
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // in_body, payload, request, method_byte, path_length, body_length,
  // path_empty, zero fill
  output logic [msrd_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic [1:0]                            out_tuser,  // kind
  output logic                                  out_tlast   // frame_end
);
  import msrd_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  logic    pop;

  logic    out_valid_r;
  result_t out_r;
  logic    skid_valid_r;
  result_t skid_r;

  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign pop       = out_valid_r && out_tready;

  msrd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step_en   (accept),
    .op        (in_tuser),
    .rx_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (out_valid_r && !pop) begin
      if (res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end else begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (out_valid_r && !pop) begin
      if (res_valid) begin
        skid_r <= res;
      end
    end else if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.frame_end;
  assign out_tdata  = {4'd0, out_r.path_empty, out_r.body_length, out_r.path_length,
                       out_r.method_byte, out_r.request, out_r.payload, out_r.in_body};

`ifndef SYNTHESIS
  // The skid stage only fills behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full while output register empty");

  // A pop with the skid stage full moves it forward and frees it.
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && pop) |=> (!skid_valid_r && out_valid_r))
    else $error("skid stage not drained on pop");

  // A held result stays unchanged until the receiver takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_r)))
    else $error("output word changed while stalled");
`endif

endmodule
